>>> sv/gsc_pkg.sv
package gsc_pkg;

   localparam int MAP_CELLS       = 65536;
   localparam int COORD_FRAC_BITS = 16;
   localparam int MAX_STEPS       = 4096;

   localparam int IDX_W  = $clog2(MAP_CELLS);
   localparam int STEP_W = $clog2(MAX_STEPS + 1);

   // shared unit operand widths
   localparam int OPA_W      = 68;
   localparam int OPB_W      = 34;
   localparam int REM_W      = 38;
   localparam int CNT_W      = 7;
   localparam int MUL_ITERS  = 34;
   localparam int DIV_ITERS  = 64;
   localparam int SQRT_ITERS = 34;

   // step length (res + 2) / 5 as a reciprocal multiply: exact for dividends below 2^33
   localparam logic [OPB_W-1:0] ETA_RECIP = 34'd13743895348;  // ceil(2^36 / 5)
   localparam int               ETA_SHIFT = 36;

   localparam logic ACT_WRITE = 1'b0;
   localparam logic ACT_CHECK = 1'b1;

   localparam logic [1:0] CELL_FREE = 2'd0;
   localparam logic [1:0] CELL_OCC  = 2'd1;
   localparam logic [1:0] CELL_UNK  = 2'd2;

   localparam logic [1:0] VERD_FREE = 2'd0;
   localparam logic [1:0] VERD_OBST = 2'd1;
   localparam logic [1:0] VERD_UNK  = 2'd2;

   localparam logic signed [7:0] RAW_OCC = 8'sd100;
   localparam logic signed [7:0] RAW_UNK = -8'sd1;

   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_RES    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ORG_X  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ORG_Y  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT = 3'd4;

   typedef enum logic [1:0] {
      ALU_MUL,
      ALU_DIV,
      ALU_SQRT
   } alu_op_type;

   typedef struct packed {
      logic             go;
      alu_op_type       op;
      logic [OPA_W-1:0] opa;
      logic [OPB_W-1:0] opb;
   } alu_cmd_type;

   typedef struct packed {
      logic             done;
      logic [OPA_W-1:0] result;
      logic             rem_nz;
   } alu_sts_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_ETA, ST_ESQ, ST_SX, ST_SY, ST_CMP, ST_RT, ST_NST,
      ST_MX0, ST_MX1, ST_MY0, ST_MY1, ST_CHK, ST_COL, ST_ROW, ST_BND,
      ST_IDX, ST_RD, ST_EVAL, ST_DONE
   } state_type;

endpackage

>>> sv/grid_segment_collision_check.sv
// Occupancy grid segment checker.
// Request: start with busy low takes one beat. req_action write stores one grid cell
// (100 occupied, -1 unknown, anything else free) in that same cycle and gives no
// result; busy stays low. req_action check walks from start toward goal in steps
// of res/5 and returns one beat on rsp_valid with verdict and the last point.
// A check first works out the step length, its square, the start distance and
// the step count, then walks step by step; a step skips the move arithmetic
// when the point jumps onto the goal. Every multiply, divide and root runs on
// one shared bit-serial unit.
// Throughput is one item at a time; busy is high for the whole check.
// Results are a strobe of one cycle; the receiver cannot stall them.
// csr_ready is always high; the user must write registers only while busy is low (not enforced).
// Reset (synchronous) returns the sequencer to idle and the registers to their
// defaults. Grid contents are not cleared: cells must be written before use.
module grid_segment_collision_check import gsc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic                 req_action,
   input  logic [15:0]          req_cell_index,
   input  logic signed [7:0]    req_cell_value,
   input  logic signed [31:0]   req_start_x,
   input  logic signed [31:0]   req_start_y,
   input  logic signed [31:0]   req_goal_x,
   input  logic signed [31:0]   req_goal_y,
   output logic                 rsp_valid,
   output logic [1:0]           rsp_verdict,
   output logic signed [31:0]   rsp_end_x,
   output logic signed [31:0]   rsp_end_y,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_wdata
);

   state_type state_ff, state_in;
   logic      pend_ff, pend_in;
   logic      init_ff, init_in;
   logic      occ_ff, occ_in;
   logic      unk_ff, unk_in;

   logic [31:0] res_ff;
   logic [31:0] orgx_ff, orgy_ff;
   logic [16:0] width_ff, height_ff;

   logic [31:0]       px_ff, px_in, py_ff, py_in, gx_ff, gx_in, gy_ff, gy_in;
   logic [31:0]       eta_ff, eta_in;
   logic [63:0]       esq_ff, esq_in;
   logic [66:0]       sq_ff, sq_in, s_ff, s_in;
   logic [OPB_W-1:0]  d_ff, d_in;
   logic [34:0]       cs_ff, cs_in;
   logic [STEP_W-1:0] steps_ff, steps_in, cnt_ff, cnt_in;
   logic [31:0]       col_ff, col_in, row_ff, row_in;
   logic [34:0]       idx_ff, idx_in;

   alu_cmd_type alu_cmd;
   alu_sts_type alu_sts;

   logic        wr_en;
   logic [1:0]  wr_code;
   logic        rd_en;
   logic [1:0]  rd_data;

   logic [31:0] res_eff;
   logic [31:0] eta_q;
   logic [32:0] dx, dy, adx, ady, nx, ny;
   logic [32:0] mv, step33;
   logic [35:0] cs_up, nst_num;
   logic [63:0] q64;
   logic        is_alu;
   logic        near_goal, off_low, off_high, idx_over, last_step;

   gsc_alu u_alu (
      .clock (clock),
      .reset (reset),
      .cmd   (alu_cmd),
      .sts   (alu_sts)
   );

   gsc_grid u_grid (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (IDX_W'(req_cell_index)),
      .wr_data (wr_code),
      .rd_en   (rd_en),
      .rd_addr (idx_ff[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   // shared combinational terms
   always_comb begin
      res_eff   = (res_ff == 32'd0) ? 32'd1 : res_ff;
      dx        = {gx_ff[31], gx_ff} - {px_ff[31], px_ff};
      dy        = {gy_ff[31], gy_ff} - {py_ff[31], py_ff};
      adx       = dx[32] ? (33'd0 - dx) : dx;
      ady       = dy[32] ? (33'd0 - dy) : dy;
      nx        = {px_ff[31], px_ff} - {orgx_ff[31], orgx_ff};
      ny        = {py_ff[31], py_ff} - {orgy_ff[31], orgy_ff};
      cs_up     = 36'(cs_ff) + 36'((64'd1 << COORD_FRAC_BITS) - 64'd1);
      nst_num   = cs_up & ~36'((64'd1 << COORD_FRAC_BITS) - 64'd1);
      q64       = alu_sts.result[63:0];
      eta_q     = alu_sts.result[ETA_SHIFT +: 32];
      mv        = alu_sts.result[32:0];
      near_goal = (s_ff <= 67'(esq_ff));
      off_low   = nx[32] | ny[32];
      off_high  = (col_ff >= 32'(width_ff)) || (row_ff >= 32'(height_ff));
      idx_over  = (idx_ff >= 35'(MAP_CELLS));
      last_step = ((cnt_ff + 1'b1) == steps_ff);
      is_alu    = (state_ff == ST_ETA) || (state_ff == ST_ESQ) || (state_ff == ST_SX) ||
                  (state_ff == ST_SY)  || (state_ff == ST_RT)  || (state_ff == ST_NST) ||
                  (state_ff == ST_MX0) || (state_ff == ST_MX1) || (state_ff == ST_MY0) ||
                  (state_ff == ST_MY1) || (state_ff == ST_COL) || (state_ff == ST_ROW);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (start && req_action == ACT_CHECK) state_in = ST_ETA;
         ST_ETA:  if (alu_sts.done) state_in = ST_ESQ;
         ST_ESQ:  if (alu_sts.done) state_in = ST_SX;
         ST_SX:   if (alu_sts.done) state_in = ST_SY;
         ST_SY:   if (alu_sts.done) state_in = init_ff ? ST_RT : ST_CMP;
         ST_CMP:  state_in = near_goal ? ST_CHK : ST_RT;
         ST_RT:   if (alu_sts.done) state_in = init_ff ? ST_NST : ST_MX0;
         ST_NST:  if (alu_sts.done) state_in = (q64 == 64'd0) ? ST_DONE : ST_SX;
         ST_MX0:  if (alu_sts.done) state_in = ST_MX1;
         ST_MX1:  if (alu_sts.done) state_in = ST_MY0;
         ST_MY0:  if (alu_sts.done) state_in = ST_MY1;
         ST_MY1:  if (alu_sts.done) state_in = ST_CHK;
         ST_CHK:  state_in = off_low ? ST_DONE : ST_COL;
         ST_COL:  if (alu_sts.done) state_in = ST_ROW;
         ST_ROW:  if (alu_sts.done) state_in = ST_BND;
         ST_BND:  state_in = off_high ? ST_DONE : ST_IDX;
         ST_IDX:  state_in = idx_over ? ST_DONE : ST_RD;
         ST_RD:   state_in = ST_EVAL;
         ST_EVAL: state_in = (rd_data == CELL_UNK || last_step) ? ST_DONE : ST_SX;
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      busy         = (state_ff != ST_IDLE);
      rsp_valid    = (state_ff == ST_DONE);
      csr_ready    = 1'b1;
      wr_en        = (state_ff == ST_IDLE) && start && (req_action == ACT_WRITE) &&
                     (32'(req_cell_index) < 32'(MAP_CELLS));
      rd_en        = (state_ff == ST_RD);
      alu_cmd.go   = is_alu && !pend_ff;
      alu_cmd.op   = ALU_MUL;
      alu_cmd.opa  = '0;
      alu_cmd.opb  = '0;
      unique case (state_ff)
         ST_ETA: begin
            alu_cmd.op  = ALU_MUL;
            alu_cmd.opa = OPA_W'(res_eff) + OPA_W'(2);
            alu_cmd.opb = ETA_RECIP;
         end
         ST_ESQ: begin
            alu_cmd.opa = OPA_W'(eta_ff);
            alu_cmd.opb = OPB_W'(eta_ff);
         end
         ST_SX: begin
            alu_cmd.opa = OPA_W'(adx);
            alu_cmd.opb = OPB_W'(adx);
         end
         ST_SY: begin
            alu_cmd.opa = OPA_W'(ady);
            alu_cmd.opb = OPB_W'(ady);
         end
         ST_RT: begin
            alu_cmd.op  = ALU_SQRT;
            alu_cmd.opa = OPA_W'(s_ff);
         end
         ST_NST: begin
            alu_cmd.op  = ALU_DIV;
            alu_cmd.opa = OPA_W'(nst_num);
            alu_cmd.opb = OPB_W'(eta_ff);
         end
         ST_MX0: begin
            alu_cmd.opa = OPA_W'(adx);
            alu_cmd.opb = OPB_W'(eta_ff);
         end
         ST_MY0: begin
            alu_cmd.opa = OPA_W'(ady);
            alu_cmd.opb = OPB_W'(eta_ff);
         end
         ST_MX1, ST_MY1: begin
            // product still sits in the unit on the issue cycle; round half up
            alu_cmd.op  = ALU_DIV;
            alu_cmd.opa = OPA_W'(q64 + 64'(d_ff >> 1));
            alu_cmd.opb = d_ff;
         end
         ST_COL: begin
            alu_cmd.op  = ALU_DIV;
            alu_cmd.opa = OPA_W'(nx[31:0]);
            alu_cmd.opb = OPB_W'(res_eff);
         end
         ST_ROW: begin
            alu_cmd.op  = ALU_DIV;
            alu_cmd.opa = OPA_W'(ny[31:0]);
            alu_cmd.opb = OPB_W'(res_eff);
         end
         default: begin
            alu_cmd.op = ALU_MUL;
         end
      endcase
      priority if (req_cell_value == RAW_OCC) wr_code = CELL_OCC;
      else if (req_cell_value == RAW_UNK)     wr_code = CELL_UNK;
      else                                    wr_code = CELL_FREE;
      rsp_verdict = occ_ff ? VERD_OBST : (unk_ff ? VERD_UNK : VERD_FREE);
      rsp_end_x   = px_ff;
      rsp_end_y   = py_ff;
   end

   // datapath next values
   always_comb begin
      pend_in  = pend_ff;
      init_in  = init_ff;
      occ_in   = occ_ff;
      unk_in   = unk_ff;
      px_in    = px_ff;
      py_in    = py_ff;
      gx_in    = gx_ff;
      gy_in    = gy_ff;
      eta_in   = eta_ff;
      esq_in   = esq_ff;
      sq_in    = sq_ff;
      s_in     = s_ff;
      d_in     = d_ff;
      cs_in    = cs_ff;
      steps_in = steps_ff;
      cnt_in   = cnt_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      idx_in   = idx_ff;
      step33   = '0;

      if (alu_cmd.go)        pend_in = 1'b1;
      else if (alu_sts.done) pend_in = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            init_in = 1'b1;
            occ_in  = 1'b0;
            unk_in  = 1'b0;
            cnt_in  = '0;
            px_in   = req_start_x;
            py_in   = req_start_y;
            gx_in   = req_goal_x;
            gy_in   = req_goal_y;
         end
         ST_ETA: if (alu_sts.done) eta_in = (eta_q == 32'd0) ? 32'd1 : eta_q;
         ST_ESQ: if (alu_sts.done) esq_in = q64;
         ST_SX:  if (alu_sts.done) sq_in = alu_sts.result[66:0];
         ST_SY:  if (alu_sts.done) s_in = sq_ff + alu_sts.result[66:0];
         ST_RT: begin
            if (alu_sts.done) begin
               d_in  = alu_sts.result[OPB_W-1:0];
               cs_in = 35'(alu_sts.result[OPB_W-1:0]) + 35'(alu_sts.rem_nz);
            end
         end
         ST_NST: begin
            if (alu_sts.done) begin
               init_in  = 1'b0;
               steps_in = (q64 > 64'(MAX_STEPS)) ? STEP_W'(MAX_STEPS) : STEP_W'(q64);
            end
         end
         ST_CMP: begin
            if (near_goal) begin
               px_in = gx_ff;
               py_in = gy_ff;
            end
         end
         ST_MX1: begin
            step33 = dx[32] ? (33'd0 - mv) : mv;
            if (alu_sts.done) px_in = px_ff + step33[31:0];
         end
         ST_MY1: begin
            step33 = dy[32] ? (33'd0 - mv) : mv;
            if (alu_sts.done) py_in = py_ff + step33[31:0];
         end
         ST_CHK: if (off_low) unk_in = 1'b1;
         ST_COL: if (alu_sts.done) col_in = q64[31:0];
         ST_ROW: if (alu_sts.done) row_in = q64[31:0];
         ST_BND: begin
            if (off_high) unk_in = 1'b1;
            idx_in = 35'(34'(row_ff[16:0]) * 34'(width_ff)) + 35'(col_ff);
         end
         ST_IDX: if (idx_over) unk_in = 1'b1;
         ST_EVAL: begin
            if (rd_data == CELL_OCC) occ_in = 1'b1;
            if (rd_data == CELL_UNK) unk_in = 1'b1;
            cnt_in = cnt_ff + 1'b1;
         end
         default: begin
            cnt_in = cnt_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         pend_ff   <= 1'b0;
         init_ff   <= 1'b1;
         occ_ff    <= 1'b0;
         unk_ff    <= 1'b0;
         res_ff    <= 32'd3277;
         orgx_ff   <= '0;
         orgy_ff   <= '0;
         width_ff  <= 17'd256;
         height_ff <= 17'd256;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
         init_ff  <= init_in;
         occ_ff   <= occ_in;
         unk_ff   <= unk_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_RES:    res_ff    <= csr_wdata;
               CSR_ORG_X:  orgx_ff   <= csr_wdata;
               CSR_ORG_Y:  orgy_ff   <= csr_wdata;
               CSR_WIDTH:  width_ff  <= csr_wdata[16:0];
               CSR_HEIGHT: height_ff <= csr_wdata[16:0];
               default:    res_ff    <= res_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      px_ff    <= px_in;
      py_ff    <= py_in;
      gx_ff    <= gx_in;
      gy_ff    <= gy_in;
      eta_ff   <= eta_in;
      esq_ff   <= esq_in;
      sq_ff    <= sq_in;
      s_ff     <= s_in;
      d_ff     <= d_in;
      cs_ff    <= cs_in;
      steps_ff <= steps_in;
      cnt_ff   <= cnt_in;
      col_ff   <= col_in;
      row_ff   <= row_in;
      idx_ff   <= idx_in;
   end

   a_one_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SX && !init_ff) |-> (cnt_ff < steps_ff))
      else $error("walk ran past its step count");

   a_done_issued: assert property (@(posedge clock) disable iff (reset)
      alu_sts.done |-> pend_ff)
      else $error("shared unit finished an operation never issued");

   a_write_quick: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_action == ACT_WRITE) |=> !busy)
      else $error("cell write made the block busy");

endmodule

>>> sv/gsc_alu.sv
// Bit-serial multiply, restoring divide and digit-by-digit square root.
module gsc_alu import gsc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  alu_cmd_type cmd,
   output alu_sts_type sts
);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   alu_op_type       op_ff, op_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in, last;
   logic [OPA_W-1:0] x_ff, x_in;
   logic [OPB_W-1:0] y_ff, y_in;
   logic [OPA_W-1:0] acc_ff, acc_in;
   logic [REM_W-1:0] rem_ff, rem_in;

   logic [OPB_W:0]   dr;
   logic [OPB_W+1:0] ddiff;
   logic [REM_W-1:0] sr, strial;
   logic [REM_W:0]   sdiff;
   logic [OPB_W-1:0] root;

   always_comb begin
      dr     = {rem_ff[OPB_W-1:0], x_ff[DIV_ITERS-1]};
      ddiff  = {1'b0, dr} - {2'b00, y_ff};
      root   = acc_ff[OPB_W-1:0];
      sr     = {rem_ff[REM_W-3:0], x_ff[OPA_W-1 -: 2]};
      strial = REM_W'({root, 2'b01});
      sdiff  = {1'b0, sr} - {1'b0, strial};

      unique case (op_ff)
         ALU_MUL:  last = CNT_W'(MUL_ITERS - 1);
         ALU_DIV:  last = CNT_W'(DIV_ITERS - 1);
         ALU_SQRT: last = CNT_W'(SQRT_ITERS - 1);
         default:  last = CNT_W'(MUL_ITERS - 1);
      endcase

      busy_in = busy_ff;
      done_in = 1'b0;
      op_in   = op_ff;
      cnt_in  = cnt_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      acc_in  = acc_ff;
      rem_in  = rem_ff;

      if (cmd.go) begin
         op_in   = cmd.op;
         busy_in = 1'b1;
         cnt_in  = '0;
         x_in    = cmd.opa;
         y_in    = cmd.opb;
         acc_in  = '0;
         rem_in  = '0;
      end else if (busy_ff) begin
         unique case (op_ff)
            ALU_MUL: begin
               if (y_ff[0]) acc_in = acc_ff + x_ff;
               x_in = x_ff << 1;
               y_in = y_ff >> 1;
            end
            ALU_DIV: begin
               // borrow clear means the divisor fits: quotient bit is one
               if (!ddiff[OPB_W+1]) rem_in = REM_W'(ddiff[OPB_W-1:0]);
               else                 rem_in = REM_W'(dr);
               x_in = {x_ff[OPA_W-2:0], ~ddiff[OPB_W+1]};
            end
            ALU_SQRT: begin
               if (!sdiff[REM_W]) begin
                  rem_in = sdiff[REM_W-1:0];
                  acc_in = OPA_W'({root[OPB_W-2:0], 1'b1});
               end else begin
                  rem_in = sr;
                  acc_in = OPA_W'({root[OPB_W-2:0], 1'b0});
               end
               x_in = x_ff << 2;
            end
            default: begin
               x_in = x_ff;
            end
         endcase
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == last) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         op_ff   <= ALU_MUL;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         op_ff   <= op_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      y_ff   <= y_in;
      acc_ff <= acc_in;
      rem_ff <= rem_in;
   end

   always_comb begin
      sts.done   = done_ff;
      sts.rem_nz = |rem_ff;
      unique case (op_ff)
         ALU_MUL:  sts.result = acc_ff;
         ALU_DIV:  sts.result = OPA_W'(x_ff[DIV_ITERS-1:0]);
         ALU_SQRT: sts.result = OPA_W'(root);
         default:  sts.result = acc_ff;
      endcase
   end

endmodule

>>> sv/gsc_grid.sv
module gsc_grid import gsc_pkg::*; (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  logic [1:0]       wr_data,
   input  logic             rd_en,
   input  logic [IDX_W-1:0] rd_addr,
   output logic [1:0]       rd_data
);

   logic [1:0] mem [MAP_CELLS];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (rd_en) rd_data <= mem[rd_addr];
   end

endmodule

>>> dv/tb_top.sv
module tb_top import gsc_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic                 req_action;
   logic [15:0]          req_cell_index;
   logic signed [7:0]    req_cell_value;
   logic signed [31:0]   req_start_x;
   logic signed [31:0]   req_start_y;
   logic signed [31:0]   req_goal_x;
   logic signed [31:0]   req_goal_y;
   logic                 rsp_valid;
   logic [1:0]           rsp_verdict;
   logic signed [31:0]   rsp_end_x;
   logic signed [31:0]   rsp_end_y;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [31:0]          csr_wdata;

   grid_segment_collision_check u_top (.*);

   typedef struct {
      logic [1:0]  verdict;
      logic [31:0] end_x;
      logic [31:0] end_y;
   } walk_result_type;

   // grid shadow and register shadow
   logic [1:0]  cell_code[MAP_CELLS];
   bit          cell_written[MAP_CELLS];
   logic [31:0] res_q;
   longint      org_x_q;
   longint      org_y_q;
   longint      width_q;
   longint      height_q;

   walk_result_type walk_q[$];
   int  fail_cnt;
   int  item_cnt;
   int  write_cnt;
   int  check_cnt;
   int  verd_cnt[3];
   int  csr_cnt;
   bit  gaps_on;

   initial begin
      clock = 1'b0;
   end
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [127:0] len_sq(logic [63:0] ax, logic [63:0] ay);
      logic [127:0] a;
      logic [127:0] b;
      a = ax;
      b = ay;
      return a * a + b * b;
   endfunction

   function automatic logic [63:0] root_dn(logic [127:0] s);
      logic [127:0] r;
      logic [127:0] t;
      r = 0;
      for (int b = 33; b >= 0; b--) begin
         t = r | (128'd1 << b);
         if (t * t <= s) r = t;
      end
      return r[63:0];
   endfunction

   function automatic longint floor_div(longint n, longint d);
      if (n >= 0) return n / d;
      return -((-n + d - 1) / d);
   endfunction

   // Walks the segment over the shadow grid. miss returns the first unwritten
   // cell the walk would read (-1 if none); the result is then not valid.
   function automatic void predict_walk(input logic [31:0] sx, sy, gx, gy,
                                        output walk_result_type r, output longint nsteps,
                                        output longint miss);
      longint px, py, gxl, gyl, dx, dy, col, row, idx, resl;
      logic [63:0] res, eta, cs, metres, steps, d, mx, my, ax, ay;
      logic [127:0] s;
      logic [1:0] code;
      bit occ, unk;
      occ = 0;
      unk = 0;
      miss = -1;
      res = (res_q == 0) ? 64'd1 : {32'd0, res_q};
      resl = longint'(res);
      eta = (res + 2) / 5;
      if (eta == 0) eta = 1;
      px = longint'(signed'(sx));
      py = longint'(signed'(sy));
      gxl = longint'(signed'(gx));
      gyl = longint'(signed'(gy));
      dx = gxl - px;
      dy = gyl - py;
      s = len_sq(dx < 0 ? -dx : dx, dy < 0 ? -dy : dy);
      cs = root_dn(s);
      if ({64'd0, cs} * {64'd0, cs} != s) cs++;
      metres = (cs + (64'd1 << COORD_FRAC_BITS) - 1) >> COORD_FRAC_BITS;
      steps = (metres << COORD_FRAC_BITS) / eta;
      if (steps > MAX_STEPS) steps = MAX_STEPS;
      nsteps = longint'(steps);
      for (longint c = 0; c < nsteps; c++) begin
         dx = gxl - px;
         dy = gyl - py;
         ax = dx < 0 ? -dx : dx;
         ay = dy < 0 ? -dy : dy;
         s = len_sq(ax, ay);
         if (s <= {64'd0, eta * eta}) begin
            px = gxl;
            py = gyl;
         end else begin
            d = root_dn(s);
            mx = (eta * ax + d / 2) / d;
            my = (eta * ay + d / 2) / d;
            px += dx < 0 ? -longint'(mx) : longint'(mx);
            py += dy < 0 ? -longint'(my) : longint'(my);
         end
         col = floor_div(px - org_x_q, resl);
         row = floor_div(py - org_y_q, resl);
         if (col < 0 || row < 0 || col >= width_q || row >= height_q) begin
            code = CELL_UNK;
         end else begin
            idx = row * width_q + col;
            if (idx >= MAP_CELLS) begin
               code = CELL_UNK;
            end else if (!cell_written[idx]) begin
               miss = idx;
               return;
            end else begin
               code = cell_code[idx];
            end
         end
         if (code == CELL_OCC) occ = 1;
         if (code == CELL_UNK) begin
            unk = 1;
            break;
         end
      end
      r.verdict = occ ? VERD_OBST : (unk ? VERD_UNK : VERD_FREE);
      r.end_x = px[31:0];
      r.end_y = py[31:0];
   endfunction

   // one request beat; start is left high on return
   task automatic send_item(input logic act, input logic [15:0] idx, input logic [7:0] val,
                            input logic [31:0] sx, sy, gx, gy);
      walk_result_type r;
      longint n, miss;
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_action     <= act;
      req_cell_index <= idx;
      req_cell_value <= val;
      req_start_x    <= sx;
      req_start_y    <= sy;
      req_goal_x     <= gx;
      req_goal_y     <= gy;
      start          <= 1'b1;
      do @(posedge clock); while (busy);
      item_cnt++;
      if (act == ACT_WRITE) begin
         write_cnt++;
         cell_written[idx] = 1;
         cell_code[idx] = (signed'(val) == RAW_OCC) ? CELL_OCC :
                          (signed'(val) == RAW_UNK) ? CELL_UNK : CELL_FREE;
      end else begin
         check_cnt++;
         predict_walk(sx, sy, gx, gy, r, n, miss);
         verd_cnt[r.verdict]++;
         walk_q = {walk_q, r};
      end
   endtask

   task automatic write_cell(input logic [15:0] idx, input logic [7:0] val);
      send_item(ACT_WRITE, idx, val, $urandom, $urandom, $urandom, $urandom);
   endtask

   function automatic logic [7:0] rand_raw();
      case ($urandom_range(0, 7))
         0, 1:    return RAW_OCC;
         2, 3:    return RAW_UNK;
         default: return 8'($urandom);
      endcase
   endfunction

   // writes whatever cells the walk would read, then sends the check
   task automatic check_segment(input logic [31:0] sx, sy, gx, gy);
      walk_result_type r;
      longint n, miss;
      forever begin
         predict_walk(sx, sy, gx, gy, r, n, miss);
         if (miss < 0) break;
         write_cell(16'(miss), rand_raw());
      end
      send_item(ACT_CHECK, 16'($urandom), 8'($urandom), sx, sy, gx, gy);
   endtask

   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (walk_q.size() != 0 || busy);
      repeat (8) @(posedge clock);
   endtask

   // leaves csr_valid high; the caller drops it after the last beat
   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_cnt++;
      case (idx)
         CSR_RES:    res_q = data;
         CSR_ORG_X:  org_x_q = longint'(signed'(data));
         CSR_ORG_Y:  org_y_q = longint'(signed'(data));
         CSR_WIDTH:  width_q = data[16:0];
         CSR_HEIGHT: height_q = data[16:0];
         default: ;
      endcase
   endtask

   task automatic set_map(input logic [31:0] res, ox, oy, w, h);
      drain();
      csr_write(CSR_RES, res);
      csr_write(CSR_ORG_X, ox);
      csr_write(CSR_ORG_Y, oy);
      csr_write(CSR_WIDTH, w);
      csr_write(CSR_HEIGHT, h);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [31:0] pt(longint v);
      return v[31:0];
   endfunction

   task automatic test_directed();
      longint r;
      write_cell(16'd0, 8'sd0);
      write_cell(16'hFFFF, -8'sd128);
      write_cell(16'd1, 8'sd127);
      write_cell(16'd2, RAW_OCC);
      write_cell(16'd3, RAW_UNK);
      write_cell(16'hFFFF, 8'sd0);
      // big cells so walks stay short: 1 m cells, 4x4 map
      set_map(32'h0001_0000, 0, 0, 4, 4);
      for (int i = 0; i < 16; i++) write_cell(16'(i), 8'sd0);
      write_cell(16'd6, RAW_OCC);
      write_cell(16'd7, RAW_UNK);
      r = 32'h0001_0000;
      check_segment(pt(r / 2), pt(r / 2), pt(r / 2), pt(r / 2));          // zero steps
      check_segment(pt(r / 2), pt(r / 2), pt(r / 2), pt(3 * r + r / 2));  // vertical up
      check_segment(pt(r / 2), pt(3 * r + r / 2), pt(r / 2), pt(r / 2));  // vertical down
      check_segment(pt(r / 2), pt(r + r / 2), pt(3 * r + r / 2), pt(r + r / 2)); // occ then unk
      check_segment(pt(-r), pt(-r), pt(r / 2), pt(r / 2));                // starts outside
      check_segment(pt(3 * r), pt(r / 2), pt(6 * r), pt(r / 2));           // leaves map
      check_segment(pt(r / 2), pt(r / 2), pt(2 * r), pt(2 * r + r / 3));   // diagonal
      // zero resolution behaves as one LSB; a 1x1 map stops at the first step
      set_map(32'd0, 32'd100, 32'd100, 1, 1);
      write_cell(16'd0, 8'sd0);
      check_segment(32'd100, 32'd100, 32'd100_000, 32'd100);
      check_segment(32'd100, 32'd100, 32'd100, 32'd100);
      // largest resolution
      set_map(32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h1_0000, 32'h1_0000);
      check_segment(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      check_segment(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
   endtask

   // random segment around the map, shrunk until the walk stays short
   task automatic random_check(input bit wild);
      walk_result_type r;
      longint n, miss, res, sx, sy, gx, gy, span;
      res = (res_q == 0) ? 1 : longint'(res_q);
      if (wild) begin
         sx = longint'(signed'(32'($urandom)));
         sy = longint'(signed'(32'($urandom)));
         gx = longint'(signed'(32'($urandom)));
         gy = longint'(signed'(32'($urandom)));
      end else begin
         sx = org_x_q + ($urandom_range(0, 21) - 1) * res + $urandom_range(0, 32'(res - 1));
         sy = org_y_q + ($urandom_range(0, 21) - 1) * res + $urandom_range(0, 32'(res - 1));
         span = 3 * res;
         gx = sx + longint'($urandom_range(0, 32'(2 * span))) - span;
         gy = sy + longint'($urandom_range(0, 32'(2 * span))) - span;
         if ($urandom_range(0, 9) == 0) gx = sx;
      end
      for (int t = 0; t < 10; t++) begin
         predict_walk(pt(sx), pt(sy), pt(gx), pt(gy), r, n, miss);
         if (n <= 16) break;
         gx = longint'(signed'(pt(sx))) + (longint'(signed'(pt(gx))) -
              longint'(signed'(pt(sx)))) / 2;
         gy = longint'(signed'(pt(sy))) + (longint'(signed'(pt(gy))) -
              longint'(signed'(pt(sy)))) / 2;
         if (t == 9) begin
            gx = sx;
            gy = sy;
         end
      end
      check_segment(pt(sx), pt(sy), pt(gx), pt(gy));
   endtask

   task automatic random_map(input bit wild);
      logic [31:0] res;
      if (wild) res = $urandom_range(32'h1000_0000, 32'hFFFF_FFFF);
      else res = $urandom_range(32'h0002_0000, 32'h0100_0000);
      set_map(res,
              $urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h0010_0000),
              $urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h0010_0000),
              $urandom_range(0, 7) == 0 ? $urandom_range(1, 65536) : $urandom_range(1, 20),
              $urandom_range(0, 7) == 0 ? $urandom_range(1, 65536) : $urandom_range(1, 20));
   endtask

   task automatic test_random(input int target);
      int phase;
      phase = 0;
      while (item_cnt < target) begin
         random_map(phase % 4 == 3);
         repeat ($urandom_range(60, 140)) begin
            if (item_cnt >= target) break;
            if ($urandom_range(0, 3) == 0) write_cell(16'($urandom), rand_raw());
            else random_check(phase % 4 == 3);
            if ($urandom_range(0, 49) == 0) drain();  // let the block empty out
         end
         phase++;
      end
   endtask

   task automatic test_tail(input int target);
      gaps_on = 0;
      random_map(0);
      while (item_cnt < target) random_check(0);
   endtask

   always @(posedge clock) begin
      walk_result_type e;
      if (!reset && rsp_valid) begin
         if (walk_q.size() == 0) begin
            $error("result beat with nothing expected");
            fail_cnt++;
         end else begin
            e = walk_q.pop_front();
            if (rsp_verdict !== e.verdict) begin
               $error("verdict: expected %0d, got %0d", e.verdict, rsp_verdict);
               fail_cnt++;
            end
            if (rsp_end_x !== e.end_x) begin
               $error("end_x: expected %h, got %h", e.end_x, rsp_end_x);
               fail_cnt++;
            end
            if (rsp_end_y !== e.end_y) begin
               $error("end_y: expected %h, got %h", e.end_y, rsp_end_y);
               fail_cnt++;
            end
         end
      end
   end

   initial begin
      #500ms;
      $display("timeout");
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      reset          = 1'b1;
      start          = 1'b0;
      req_action     = ACT_WRITE;
      req_cell_index = '0;
      req_cell_value = '0;
      req_start_x    = '0;
      req_start_y    = '0;
      req_goal_x     = '0;
      req_goal_y     = '0;
      csr_valid      = 1'b0;
      csr_index      = CSR_RES;
      csr_wdata      = '0;
      res_q    = 32'd3277;
      org_x_q  = 0;
      org_y_q  = 0;
      width_q  = 256;
      height_q = 256;
      gaps_on  = 1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(1650);
      test_tail(1850);
      drain();
      repeat (500) @(posedge clock);
      if (walk_q.size() != 0) begin
         $error("%0d results never arrived", walk_q.size());
         fail_cnt++;
      end
      $display("covered %0d beats: %0d cell writes, %0d segment checks, %0d csr writes",
               item_cnt, write_cnt, check_cnt, csr_cnt);
      $display("verdicts seen: free %0d, obstacle %0d, unknown %0d",
               verd_cnt[0], verd_cnt[1], verd_cnt[2]);
      if (fail_cnt == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
